@@ sv/q4dp_pkg.sv @@
// Package for the q4 block-quantized dot product core.
// Holds the field widths, the queue entry type and the queue status type.
// No dependencies; every other file of the block imports it.
package q4dp_pkg;

    localparam int NIB_W      = 4;
    localparam int WEIGHT_W   = 8;
    localparam int ACT_W      = 16;
    localparam int SCALE_W    = 16;
    localparam int PROD_W     = NIB_W + ACT_W;
    localparam int CONTRIB_W  = PROD_W + 1;
    localparam int IN_DATA_W  = WEIGHT_W + 2 * ACT_W + SCALE_W;
    localparam int DOT_W      = 48;
    localparam int EXT_W      = 64;

    typedef struct packed {
        logic signed [CONTRIB_W-1:0] contrib;
        logic signed [SCALE_W-1:0]   scale;
        logic                        close;
        logic                        last;
    } q4dp_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q4dp_fifo_status_t;

endpackage

@@ sv/q4_block_quant_dot_product_core.sv @@
// Top level of the q4 block-quantized dot product core.
// Instantiates q4dp_front, q4dp_fifo and q4dp_back; depends on q4dp_pkg.

// Takes one packed weight byte per cycle while the queue is not full, and
// sustains that while results are taken. A byte goes through the front end
// into a four-entry queue and a three-stage back end: block accumulation,
// the scale multiply, and the saturating add into the row total, each of them
// registered. The back end holds only while a finished result is not taken;
// the queue then absorbs up to four more bytes.
module q4_block_quant_dot_product_core #(
    parameter int BLOCK_SIZE  = 32,
    parameter int TOTAL_WIDTH = 48
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // packed_weights, act_even, act_odd, block_scale
    input  logic [q4dp_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // row_end
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // dot_sum
    output logic [q4dp_pkg::DOT_W-1:0]     m_axis_tdata,
    // saturated
    output logic                           m_axis_tuser
);
    import q4dp_pkg::*;

    q4dp_fifo_status_t fifo_status;
    q4dp_entry_t       wr_entry;
    q4dp_entry_t       rd_entry;
    logic              push;
    logic              pop;

    q4dp_front #(
        .BLOCK_SIZE(BLOCK_SIZE)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .fifo_status  (fifo_status),
        .push         (push),
        .entry        (wr_entry)
    );

    q4dp_fifo #(
        .DEPTH(4)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_entry(wr_entry),
        .pop     (pop),
        .rd_entry(rd_entry),
        .status  (fifo_status)
    );

    q4dp_back #(
        .BLOCK_SIZE (BLOCK_SIZE),
        .TOTAL_WIDTH(TOTAL_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .fifo_status  (fifo_status),
        .entry        (rd_entry),
        .pop          (pop),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !fifo_status.full)
        else $error("Request written into a full queue.");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !fifo_status.empty)
        else $error("Request read from an empty queue.");

    a_status_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        !(fifo_status.full && fifo_status.empty))
        else $error("Queue reports full and empty together.");

    a_full_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (fifo_status.full && !pop) |=> fifo_status.full)
        else $error("Queue lost a request while nothing was read.");

endmodule

@@ sv/q4dp_front.sv @@
// Front end of the q4 dot product core: takes requests, forms the byte
// contribution and marks block and row closes. Depends on q4dp_pkg.
module q4dp_front #(
    parameter int BLOCK_SIZE = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [q4dp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tlast,
    input  q4dp_pkg::q4dp_fifo_status_t      fifo_status,
    output logic                             push,
    output q4dp_pkg::q4dp_entry_t            entry
);
    import q4dp_pkg::*;

    localparam int BPB = BLOCK_SIZE / 2;
    localparam int CW  = (BPB > 1) ? $clog2(BPB) : 1;
    localparam logic [CW-1:0] LAST_CNT = CW'(BPB - 1);

    logic [WEIGHT_W-1:0]     packed_weights;
    logic signed [ACT_W-1:0] act_even;
    logic signed [ACT_W-1:0] act_odd;
    logic signed [NIB_W-1:0] q_lo;
    logic signed [NIB_W-1:0] q_hi;
    logic signed [PROD_W-1:0] prod_lo;
    logic signed [PROD_W-1:0] prod_hi;
    logic                    close;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;

    assign packed_weights = s_axis_tdata[WEIGHT_W-1:0];
    assign act_even       = s_axis_tdata[WEIGHT_W+ACT_W-1:WEIGHT_W];
    assign act_odd        = s_axis_tdata[WEIGHT_W+2*ACT_W-1:WEIGHT_W+ACT_W];

    // Subtracting the offset of eight from a nibble just flips its top bit.
    assign q_lo    = {~packed_weights[3], packed_weights[2:0]};
    assign q_hi    = {~packed_weights[7], packed_weights[6:4]};
    assign prod_lo = q_lo * act_even;
    assign prod_hi = q_hi * act_odd;

    assign s_axis_tready = !fifo_status.full;
    assign push          = s_axis_tvalid && s_axis_tready;
    assign close         = s_axis_tlast || (count_reg == LAST_CNT);

    assign entry.contrib = CONTRIB_W'(prod_lo) + CONTRIB_W'(prod_hi);
    assign entry.scale   = s_axis_tdata[IN_DATA_W-1:WEIGHT_W+2*ACT_W];
    assign entry.close   = close;
    assign entry.last    = s_axis_tlast;

    always_comb
    begin
        count_next = count_reg;
        if (push)
        begin
            count_next = close ? '0 : count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

@@ sv/q4dp_fifo.sv @@
// Short queue between the front and back of the q4 dot product core.
// Holds q4dp_entry_t requests; depends on q4dp_pkg.
module q4dp_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  q4dp_pkg::q4dp_entry_t       wr_entry,
    input  logic                        pop,
    output q4dp_pkg::q4dp_entry_t       rd_entry,
    output q4dp_pkg::q4dp_fifo_status_t status
);
    import q4dp_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    q4dp_entry_t       mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign rd_entry     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

@@ sv/q4dp_back.sv @@
// Back end of the q4 dot product core: block accumulation, scale multiply,
// saturating row total and the output register. Depends on q4dp_pkg.
module q4dp_back #(
    parameter int BLOCK_SIZE  = 32,
    parameter int TOTAL_WIDTH = 48
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  q4dp_pkg::q4dp_fifo_status_t   fifo_status,
    input  q4dp_pkg::q4dp_entry_t         entry,
    output logic                          pop,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [q4dp_pkg::DOT_W-1:0]    m_axis_tdata,
    output logic                          m_axis_tuser
);
    import q4dp_pkg::*;

    localparam int BPB = BLOCK_SIZE / 2;
    localparam int BSW = CONTRIB_W + $clog2(BPB);
    localparam int PW  = BSW + SCALE_W;
    localparam int SW  = ((TOTAL_WIDTH > PW) ? TOTAL_WIDTH : PW) + 1;
    localparam logic signed [TOTAL_WIDTH-1:0] TOT_MAX = {1'b0, {(TOTAL_WIDTH-1){1'b1}}};
    localparam logic signed [TOTAL_WIDTH-1:0] TOT_MIN = {1'b1, {(TOTAL_WIDTH-1){1'b0}}};

    logic                          adv;
    logic signed [BSW-1:0]         acc;
    logic signed [BSW-1:0]         bsum_reg;
    logic signed [BSW-1:0]         bsum_next;
    logic signed [BSW-1:0]         closed_reg;
    logic signed [SCALE_W-1:0]     cscale_reg;
    logic                          c_last_reg;
    logic                          c_valid_reg;
    logic                          c_valid_next;
    logic signed [PW-1:0]          prod_reg;
    logic                          p_last_reg;
    logic                          p_valid_reg;
    logic                          p_valid_next;
    logic signed [SW-1:0]          sum_w;
    logic [SW-TOTAL_WIDTH:0]       upper;
    logic                          fits;
    logic signed [TOTAL_WIDTH-1:0] tot_new;
    logic                          clip_new;
    logic signed [EXT_W-1:0]       tot_ext;
    logic signed [TOTAL_WIDTH-1:0] total_reg;
    logic signed [TOTAL_WIDTH-1:0] total_next;
    logic                          clip_reg;
    logic                          clip_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [DOT_W-1:0]              out_dot_reg;
    logic                          out_sat_reg;

    // The whole back end moves together; it holds only while a result waits.
    assign adv = !out_valid_reg || m_axis_tready;
    assign pop = adv && !fifo_status.empty;
    assign acc = bsum_reg + BSW'(entry.contrib);

    assign sum_w    = SW'(total_reg) + SW'(prod_reg);
    assign upper    = sum_w[SW-1:TOTAL_WIDTH-1];
    assign fits     = (&upper) || !(|upper);
    assign tot_new  = fits ? sum_w[TOTAL_WIDTH-1:0] : (sum_w[SW-1] ? TOT_MIN : TOT_MAX);
    assign clip_new = clip_reg || !fits;
    assign tot_ext  = EXT_W'(tot_new);

    always_comb
    begin
        bsum_next      = bsum_reg;
        c_valid_next   = c_valid_reg;
        p_valid_next   = p_valid_reg;
        total_next     = total_reg;
        clip_next      = clip_reg;
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            c_valid_next   = pop && entry.close;
            p_valid_next   = c_valid_reg;
            out_valid_next = p_valid_reg && p_last_reg;
            if (pop)
            begin
                bsum_next = entry.close ? '0 : acc;
            end
            if (p_valid_reg)
            begin
                total_next = p_last_reg ? '0 : tot_new;
                clip_next  = p_last_reg ? 1'b0 : clip_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bsum_reg      <= '0;
            c_valid_reg   <= 1'b0;
            p_valid_reg   <= 1'b0;
            total_reg     <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bsum_reg      <= bsum_next;
            c_valid_reg   <= c_valid_next;
            p_valid_reg   <= p_valid_next;
            total_reg     <= total_next;
            clip_reg      <= clip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && entry.close)
        begin
            closed_reg <= acc;
            cscale_reg <= entry.scale;
            c_last_reg <= entry.last;
        end
        if (adv)
        begin
            prod_reg   <= closed_reg * cscale_reg;
            p_last_reg <= c_last_reg;
        end
        if (adv && p_valid_reg && p_last_reg)
        begin
            out_dot_reg <= tot_ext[DOT_W-1:0];
            out_sat_reg <= clip_new;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_dot_reg;
    assign m_axis_tuser  = out_sat_reg;

endmodule
